/* rtl/im2col_pkg.sv */
// ----------------------------------------------------------------------------
// im2col address generator package
// shared types, register indexes and limits of the patch address generator
// ----------------------------------------------------------------------------
`default_nettype none

package im2col_pkg;

  localparam int unsigned MaxWidth  = 256;
  localparam int unsigned MaxHeight = 256;
  localparam int unsigned MaxKernel = 8;
  localparam int unsigned MaxBatch  = 16;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned IdxW     = 20;
  localparam int unsigned CoordW   = 10;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 3'd0,
    CfgImageHeight = 3'd1,
    CfgKernelSize  = 3'd2,
    CfgPadAmount   = 3'd3,
    CfgStepSize    = 3'd4,
    CfgBatchCount  = 3'd5
  } cfg_reg_e;

  // window snapshot handed to the tap datapath
  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [IdxW-1:0]   base;
    logic [IdxW-1:0]   row;
    logic              last_win;
  } window_t;

  typedef struct packed {
    logic [IdxW-1:0] source_index;
    logic            is_padding;
    logic [5:0]      tap_position;
    logic [IdxW-1:0] patch_row;
    logic            last_tap;
    logic            last_window;
  } tap_t;

endpackage

`default_nettype wire

/* rtl/im2col_address_generator.sv */
// ----------------------------------------------------------------------------
// im2col address generator
// convolution patch address generator over a batch of padded images
// ----------------------------------------------------------------------------
// Each request yields one tap per kernel position, the square of the kernel
// side, one per cycle while the output is taken; the pace is set by the tap
// counter that walks the kernel. The next request is taken in the cycle that
// issues the last tap of the current window, and the output register lets a
// tap wait while the next one is being formed, so windows follow without gaps.
`default_nettype none

module im2col_address_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        restart_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [19:0] source_index_o,
  output logic        is_padding_o,
  output logic [5:0]  tap_position_o,
  output logic [19:0] patch_row_o,
  output logic        last_tap_o,
  output logic        last_window_o
);

  // configuration
  logic [8:0] width_q, height_q;
  logic [3:0] ksize_q, step_q;
  logic [2:0] pad_q;
  logic [4:0] batch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd28;
      height_q <= 9'd28;
      ksize_q  <= 4'd3;
      pad_q    <= 3'd1;
      step_q   <= 4'd1;
      batch_q  <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        im2col_pkg::CfgImageWidth:  width_q  <= cfg_data_i;
        im2col_pkg::CfgImageHeight: height_q <= cfg_data_i;
        im2col_pkg::CfgKernelSize:  ksize_q  <= cfg_data_i[3:0];
        im2col_pkg::CfgPadAmount:   pad_q    <= cfg_data_i[2:0];
        im2col_pkg::CfgStepSize:    step_q   <= cfg_data_i[3:0];
        im2col_pkg::CfgBatchCount:  batch_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w_eff, h_eff;
  logic [3:0] k_eff, s_eff;
  logic [4:0] b_eff;

  always_comb begin
    w_eff = (width_q == '0) ? 9'd1 :
            (width_q > 9'(im2col_pkg::MaxWidth)) ? 9'(im2col_pkg::MaxWidth) : width_q;
    h_eff = (height_q == '0) ? 9'd1 :
            (height_q > 9'(im2col_pkg::MaxHeight)) ? 9'(im2col_pkg::MaxHeight) : height_q;
    k_eff = (ksize_q == '0) ? 4'd1 :
            (ksize_q > 4'(im2col_pkg::MaxKernel)) ? 4'(im2col_pkg::MaxKernel) : ksize_q;
    s_eff = (step_q == '0) ? 4'd1 : step_q;
    b_eff = (batch_q == '0) ? 5'd1 :
            (batch_q > 5'(im2col_pkg::MaxBatch)) ? 5'(im2col_pkg::MaxBatch) : batch_q;
  end

  // window walk state
  logic [9:0]  wx_q, wy_q, wx_d, wy_d;
  logic [19:0] base_q, row_q, base_d, row_d;
  logic [4:0]  bidx_q, bidx_d;

  logic [9:0]  neg_pad;
  logic [9:0]  cur_x, cur_y;
  logic [19:0] cur_base, cur_row;
  logic [4:0]  cur_bidx;
  logic signed [11:0] row_sum, col_sum, row_lim, col_lim;
  logic        row_end, col_end, img_end, last_win;
  logic [17:0] area;

  logic in_accept;
  logic busy_q;
  logic issue;

  im2col_pkg::window_t win_q;
  im2col_pkg::tap_t    tap;
  logic [2:0] kx_q, ky_q;

  assign neg_pad  = 10'd0 - {7'b0, pad_q};
  assign cur_x    = restart_i ? neg_pad : wx_q;
  assign cur_y    = restart_i ? neg_pad : wy_q;
  assign cur_base = restart_i ? '0 : base_q;
  assign cur_row  = restart_i ? '0 : row_q;
  assign cur_bidx = restart_i ? '0 : bidx_q;

  assign row_sum = {{2{cur_x[9]}}, cur_x} + {8'b0, s_eff} + {8'b0, k_eff};
  assign col_sum = {{2{cur_y[9]}}, cur_y} + {8'b0, s_eff} + {8'b0, k_eff};
  assign row_lim = {3'b0, w_eff} + {9'b0, pad_q};
  assign col_lim = {3'b0, h_eff} + {9'b0, pad_q};
  assign row_end = row_sum > row_lim;
  assign col_end = col_sum > col_lim;
  assign img_end = ({1'b0, cur_bidx} + 6'd1) >= {1'b0, b_eff};
  assign last_win = row_end && col_end && img_end;
  assign area     = w_eff * h_eff;

  always_comb begin
    wx_d   = cur_x;
    wy_d   = cur_y;
    base_d = cur_base;
    row_d  = cur_row + 20'd1;
    bidx_d = cur_bidx;
    if (last_win) begin
      wx_d   = neg_pad;
      wy_d   = neg_pad;
      base_d = '0;
      row_d  = '0;
      bidx_d = '0;
    end else if (!row_end) begin
      wx_d = cur_x + {6'b0, s_eff};
    end else if (!col_end) begin
      wx_d = neg_pad;
      wy_d = cur_y + {6'b0, s_eff};
    end else begin
      wx_d   = neg_pad;
      wy_d   = neg_pad;
      base_d = cur_base + {2'b0, area};
      bidx_d = cur_bidx + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wx_q   <= 10'h3FF;
      wy_q   <= 10'h3FF;
      base_q <= '0;
      row_q  <= '0;
      bidx_q <= '0;
    end else if (in_accept) begin
      wx_q   <= wx_d;
      wy_q   <= wy_d;
      base_q <= base_d;
      row_q  <= row_d;
      bidx_q <= bidx_d;
    end
  end

  // tap walk over the accepted window
  assign issue      = busy_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !busy_q || (issue && tap.last_tap);
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      win_q <= '{x: cur_x, y: cur_y, base: cur_base, row: cur_row, last_win: last_win};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kx_q   <= '0;
      ky_q   <= '0;
    end else if (in_accept) begin
      busy_q <= 1'b1;
      kx_q   <= '0;
      ky_q   <= '0;
    end else if (issue) begin
      if (tap.last_tap) begin
        busy_q <= 1'b0;
      end else if ({1'b0, kx_q} == (k_eff - 4'd1)) begin
        kx_q <= '0;
        ky_q <= ky_q + 3'd1;
      end else begin
        kx_q <= kx_q + 3'd1;
      end
    end
  end

  im2col_tap_calc u_tap_calc (
    .win_i    (win_q),
    .kx_i     (kx_q),
    .ky_i     (ky_q),
    .width_i  (w_eff),
    .height_i (h_eff),
    .ksize_i  (k_eff),
    .tap_o    (tap)
  );

  // output register
  im2col_pkg::tap_t out_q;
  logic             out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (issue) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_q <= tap;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign source_index_o = out_q.source_index;
  assign is_padding_o   = out_q.is_padding;
  assign tap_position_o = out_q.tap_position;
  assign patch_row_o    = out_q.patch_row;
  assign last_tap_o     = out_q.last_tap;
  assign last_window_o  = out_q.last_window;

  // assertions
  a_accept_starts_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q && (kx_q == 3'd0) && (ky_q == 3'd0))
    else $error("tap walk not restarted on request");

  a_stall_holds_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !issue && !in_accept) |=> busy_q && $stable(kx_q) && $stable(ky_q))
    else $error("tap walk moved while output stalled");

  a_pad_zero_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_padding_o) |-> (source_index_o == '0))
    else $error("padding tap with nonzero index");

endmodule

`default_nettype wire

/* rtl/im2col_tap_calc.sv */
// ----------------------------------------------------------------------------
// im2col tap calculation
// source index, padding flag and tap position of one kernel tap of a window
// ----------------------------------------------------------------------------
`default_nettype none

module im2col_tap_calc (
  input  im2col_pkg::window_t win_i,
  input  logic [2:0]          kx_i,
  input  logic [2:0]          ky_i,
  input  logic [8:0]          width_i,
  input  logic [8:0]          height_i,
  input  logic [3:0]          ksize_i,
  output im2col_pkg::tap_t    tap_o
);

  logic [10:0] x;
  logic [10:0] y;
  logic        pad;
  logic [17:0] row_off;
  logic [19:0] idx;
  logic [6:0]  kprod;
  logic [6:0]  tap_pos;

  // coordinates carry a sign bit on top
  assign x = {win_i.x[9], win_i.x} + {8'b0, kx_i};
  assign y = {win_i.y[9], win_i.y} + {8'b0, ky_i};

  assign pad = x[10] || (x[9:0] >= {1'b0, width_i}) ||
               y[10] || (y[9:0] >= {1'b0, height_i});

  assign row_off = y[8:0] * width_i;
  assign idx     = win_i.base + {2'b0, row_off} + {11'b0, x[8:0]};

  assign kprod   = {4'b0, ky_i} * {3'b0, ksize_i};
  assign tap_pos = kprod + {4'b0, kx_i};

  always_comb begin
    tap_o.source_index = pad ? '0 : idx;
    tap_o.is_padding   = pad;
    tap_o.tap_position = tap_pos[5:0];
    tap_o.patch_row    = win_i.row;
    tap_o.last_tap     = ({1'b0, kx_i} == (ksize_i - 4'd1)) &&
                         ({1'b0, ky_i} == (ksize_i - 4'd1));
    tap_o.last_window  = win_i.last_win;
  end

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// im2col address generator testbench
// Sends window requests over a valid/ready channel and checks every tap
// against an in-bench predictor of the window walk. Runs directed register
// settings, including saturating values and mid-run changes, and then
// random phases with random idling on both channels. It also includes a long
// output stall and waits for the output to drain.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int SettleCycles = 16;
  localparam int StepCap      = 15;
  localparam int RandomItems  = 400;

  typedef enum int {IdleNone, IdleSome, IdleFull} idle_mode_e;

  typedef struct packed {
    logic restart;
    logic drain;
  } window_req_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [8:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        restart_i   = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [19:0] source_index_o;
  logic        is_padding_o;
  logic [5:0]  tap_position_o;
  logic [19:0] patch_row_o;
  logic        last_tap_o;
  logic        last_window_o;

  // register copies as written, masked to register width
  bit [8:0]  width_r, height_r;
  bit [3:0]  kernel_r, step_r;
  bit [2:0]  pad_r;
  bit [4:0]  batch_r;

  // window walk state
  int        win_x, win_y;
  bit [19:0] img_base, patch_cnt;
  bit [4:0]  img_idx;

  im2col_pkg::tap_t expected_taps[$];
  window_req_t      pending_reqs[$];
  window_req_t      staged_req;
  bit               staged, sending;
  int               gap_left;
  bit               req_taken, tap_taken;
  idle_mode_e       tx_mode = IdleNone;
  idle_mode_e       rx_mode = IdleNone;
  int               hold_len, hold_asked, hold_seen, hold_left, rx_wait;
  int               fail_count;
  int               random_sent, phase_idx, phase_len;

  im2col_address_generator dut (.*);

  initial begin : clock_gen
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int draw_wait(input idle_mode_e mode);
    case (mode)
      IdleFull: return $urandom_range(0, 19);
      IdleSome: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      default:  return 0;
    endcase
  endfunction

  task automatic go_home();
    win_x     = -int'(pad_r);
    win_y     = -int'(pad_r);
    img_base  = '0;
    patch_cnt = '0;
    img_idx   = '0;
  endtask

  task automatic predict_window(input logic restart);
    int               w, h, k, p, s, b, x, y, ky, kx;
    bit               row_end, col_end, last_win, pad;
    int unsigned      idx;
    im2col_pkg::tap_t t;
    w = clip(int'(width_r), 1, int'(im2col_pkg::MaxWidth));
    h = clip(int'(height_r), 1, int'(im2col_pkg::MaxHeight));
    k = clip(int'(kernel_r), 1, int'(im2col_pkg::MaxKernel));
    p = int'(pad_r);
    s = clip(int'(step_r), 1, StepCap);
    b = clip(int'(batch_r), 1, int'(im2col_pkg::MaxBatch));
    if (restart) go_home();
    row_end  = (win_x + s + k) > (w + p);
    col_end  = (win_y + s + k) > (h + p);
    last_win = row_end && col_end && (int'(img_idx) + 1 >= b);
    for (ky = 0; ky < k; ky++) begin
      for (kx = 0; kx < k; kx++) begin
        x   = win_x + kx;
        y   = win_y + ky;
        pad = (x < 0) || (x >= w) || (y < 0) || (y >= h);
        idx = pad ? 0 : img_base + y * w + x;
        t.source_index = idx[19:0];
        t.is_padding   = pad;
        t.tap_position = 6'(ky * k + kx);
        t.patch_row    = patch_cnt;
        t.last_tap     = (ky == k - 1) && (kx == k - 1);
        t.last_window  = last_win;
        expected_taps.push_back(t);
      end
    end
    if (last_win) begin
      go_home();
    end else begin
      patch_cnt = patch_cnt + 1'b1;
      if (!row_end) begin
        win_x = win_x + s;
      end else if (!col_end) begin
        win_x = -p;
        win_y = win_y + s;
      end else begin
        win_x    = -p;
        win_y    = -p;
        img_base = img_base + 20'(w * h);
        img_idx  = img_idx + 1'b1;
      end
    end
  endtask

  task automatic check_tap(input im2col_pkg::tap_t got);
    im2col_pkg::tap_t want;
    if (expected_taps.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected tap: idx %0d pad %0b pos %0d row %0d last %0b/%0b",
                 got.source_index, got.is_padding, got.tap_position, got.patch_row,
                 got.last_tap, got.last_window);
    end else begin
      want = expected_taps.pop_front();
      if (got != want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("tap mismatch: exp idx %0d pad %0b pos %0d row %0d last %0b/%0b, %s",
                   want.source_index, want.is_padding, want.tap_position, want.patch_row,
                   want.last_tap, want.last_window,
                   $sformatf("got idx %0d pad %0b pos %0d row %0d last %0b/%0b",
                             got.source_index, got.is_padding, got.tap_position,
                             got.patch_row, got.last_tap, got.last_window));
      end
    end
  endtask

  task automatic write_reg(input im2col_pkg::cfg_reg_e r, input logic [8:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    case (r)
      im2col_pkg::CfgImageWidth:  width_r  = v;
      im2col_pkg::CfgImageHeight: height_r = v;
      im2col_pkg::CfgKernelSize:  kernel_r = v[3:0];
      im2col_pkg::CfgPadAmount:   pad_r    = v[2:0];
      im2col_pkg::CfgStepSize:    step_r   = v[3:0];
      im2col_pkg::CfgBatchCount:  batch_r  = v[4:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [8:0] draw_reg(input im2col_pkg::cfg_reg_e r);
    logic [8:0] v;
    v = 9'($urandom);
    case (r)
      im2col_pkg::CfgImageWidth, im2col_pkg::CfgImageHeight: begin
        case ($urandom_range(0, 9))
          0: v = 9'd1;
          1: v = 9'd256;
          2: v = 9'($urandom_range(0, 511));
          3: v = 9'($urandom_range(7, 16));
          default: v = 9'($urandom_range(1, 6));
        endcase
      end
      im2col_pkg::CfgKernelSize:
        v[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 4));
      im2col_pkg::CfgPadAmount:
        v[2:0] = 3'($urandom_range(0, 7));
      im2col_pkg::CfgStepSize:
        v[3:0] = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 3));
      im2col_pkg::CfgBatchCount:
        v[4:0] = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(1, 3));
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_request(input logic restart, input logic drain);
    pending_reqs.push_back({restart, drain});
  endtask

  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || staged || sending || expected_taps.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin : driver
    if (rst_ni) begin
      if (req_taken) sending = 1'b0;
      if (!sending && !staged && pending_reqs.size() != 0) begin
        staged_req = pending_reqs.pop_front();
        staged     = 1'b1;
        gap_left   = draw_wait(tx_mode);
      end
      if (staged) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!staged_req.drain || expected_taps.size() == 0) begin
          restart_i  <= staged_req.restart;
          in_valid_i <= 1'b1;
          sending    = 1'b1;
          staged     = 1'b0;
        end
      end
      if (!sending) in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin : receiver
    if (rst_ni) begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (tap_taken) rx_wait = draw_wait(rx_mode);
        if (rx_wait > 0) begin
          rx_wait--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    req_taken = rst_ni && in_valid_i && in_ready_o;
    tap_taken = rst_ni && out_valid_o && out_ready_i;
    if (req_taken) predict_window(restart_i);
    if (tap_taken)
      check_tap({source_index_o, is_padding_o, tap_position_o, patch_row_o,
                 last_tap_o, last_window_o});
  end

  initial begin : stimulus
    width_r  = 9'd28;
    height_r = 9'd28;
    kernel_r = 4'd3;
    pad_r    = 3'd1;
    step_r   = 4'd1;
    batch_r  = 5'd1;
    go_home();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // register reset values, then a restart and a drain pause
    queue_request(1'b0, 1'b0);
    queue_request(1'b0, 1'b0);
    queue_request(1'b0, 1'b1);
    queue_request(1'b1, 1'b0);
    wait_quiet();

    // zero registers saturate up, kernel far bigger than the image
    tx_mode = IdleFull;
    rx_mode = IdleSome;
    write_reg(im2col_pkg::CfgImageWidth, 9'd0);
    write_reg(im2col_pkg::CfgImageHeight, 9'd1);
    write_reg(im2col_pkg::CfgKernelSize, 9'd15);
    write_reg(im2col_pkg::CfgPadAmount, 9'd0);
    write_reg(im2col_pkg::CfgStepSize, 9'd0);
    write_reg(im2col_pkg::CfgBatchCount, 9'd0);
    repeat (3) queue_request(1'b0, 1'b0);
    wait_quiet();

    // oversized width and batch, widest pad and step
    tx_mode = IdleSome;
    rx_mode = IdleFull;
    write_reg(im2col_pkg::CfgImageWidth, 9'd511);
    write_reg(im2col_pkg::CfgImageHeight, 9'd2);
    write_reg(im2col_pkg::CfgKernelSize, 9'd8);
    write_reg(im2col_pkg::CfgPadAmount, 9'd7);
    write_reg(im2col_pkg::CfgStepSize, 9'd15);
    write_reg(im2col_pkg::CfgBatchCount, 9'd31);
    queue_request(1'b1, 1'b0);
    repeat (3) queue_request(1'b0, 1'b0);
    wait_quiet();

    // small batch walk, then pad and batch count change mid-run
    tx_mode = IdleNone;
    rx_mode = IdleNone;
    write_reg(im2col_pkg::CfgImageWidth, 9'd3);
    write_reg(im2col_pkg::CfgImageHeight, 9'd2);
    write_reg(im2col_pkg::CfgKernelSize, 9'd2);
    write_reg(im2col_pkg::CfgPadAmount, 9'd0);
    write_reg(im2col_pkg::CfgStepSize, 9'd1);
    write_reg(im2col_pkg::CfgBatchCount, 9'd3);
    queue_request(1'b1, 1'b0);
    repeat (4) queue_request(1'b0, 1'b0);
    wait_quiet();
    write_reg(im2col_pkg::CfgPadAmount, 9'd1);
    write_reg(im2col_pkg::CfgBatchCount, 9'd1);
    repeat (4) queue_request(1'b0, 1'b0);
    wait_quiet();

    // random phases
    while (random_sent < RandomItems) begin
      for (int r = 0; r <= int'(im2col_pkg::CfgBatchCount); r++)
        if ($urandom_range(0, 3) != 0)
          write_reg(im2col_pkg::cfg_reg_e'(r), draw_reg(im2col_pkg::cfg_reg_e'(r)));
      tx_mode = idle_mode_e'($urandom_range(0, 2));
      rx_mode = idle_mode_e'($urandom_range(0, 2));
      if (phase_idx == 1 || $urandom_range(0, 7) == 0) begin
        tx_mode  = IdleNone;
        hold_len = $urandom_range(200, 400);
        hold_asked++;
      end
      phase_len = $urandom_range(10, 50);
      queue_request(1'($urandom_range(0, 1)), 1'b0);
      for (int i = 1; i < phase_len; i++)
        queue_request($urandom_range(0, 19) == 0, $urandom_range(0, 24) == 0);
      random_sent += phase_len;
      phase_idx++;
      wait_quiet();
    end

    if (fail_count == 0 && expected_taps.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin : watchdog
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
